/* rtl/core/mkeg_pkg.sv */
// Shared types, constants, Morse table and microcode for the Morse keying event generator.
package mkeg_pkg;

  localparam int TIME_BITS     = 56;
  localparam int POSITION_BITS = 16;
  localparam int LEN_BITS      = 48;
  localparam int CFG_IDX_BITS  = 3;
  localparam int CODE_BITS     = 6;

  localparam logic [CFG_IDX_BITS-1:0] CFG_MODE       = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_DOT        = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] CFG_DASH       = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] CFG_ELEM_GAP   = 3'd3;
  localparam logic [CFG_IDX_BITS-1:0] CFG_LETTER_GAP = 3'd4;
  localparam logic [CFG_IDX_BITS-1:0] CFG_WORD_GAP   = 3'd5;

  localparam logic [1:0] MODE_OOK  = 2'd0;
  localparam logic [1:0] MODE_FSK  = 2'd1;
  localparam logic [1:0] MODE_DFCW = 2'd2;

  localparam logic [2:0] KIND_DOT  = 3'd0;
  localparam logic [2:0] KIND_DASH = 3'd1;
  localparam logic [2:0] KIND_EGAP = 3'd2;
  localparam logic [2:0] KIND_LGAP = 3'd3;
  localparam logic [2:0] KIND_WGAP = 3'd4;

  localparam logic [LEN_BITS-1:0] RST_DOT        = 48'd1000000000;
  localparam logic [LEN_BITS-1:0] RST_DASH       = 48'd3000000000;
  localparam logic [LEN_BITS-1:0] RST_ELEM_GAP   = 48'd1000000000;
  localparam logic [LEN_BITS-1:0] RST_LETTER_GAP = 48'd3000000000;
  localparam logic [LEN_BITS-1:0] RST_WORD_GAP   = 48'd7000000000;

  typedef enum logic [2:0] {
    ST_WAIT,
    ST_GAP,
    ST_MARK,
    ST_EGAP,
    ST_ERR
  } step_t;

  typedef enum logic [2:0] {
    EMIT_NONE,
    EMIT_LEAD,
    EMIT_KEY,
    EMIT_EGAP,
    EMIT_ERR
  } emit_t;

  typedef enum logic [1:0] {
    COND_DISPATCH,
    COND_EMIT,
    COND_MORE
  } cond_t;

  typedef struct packed {
    logic  take;
    emit_t emit;
    cond_t cond;
    logic  commit;
    step_t next_a;
    step_t next_b;
  } ctrl_t;

  typedef struct packed {
    logic accept;
    logic blank;
    logic bad;
    logic prev;
    logic done;
    logic more;
  } status_t;

  // Pattern is left-aligned: bit 5 is the first element, 1 means dash.
  typedef struct packed {
    logic                 ok;
    logic [2:0]           len;
    logic [CODE_BITS-1:0] pat;
  } morse_t;

  function automatic logic is_blank(input logic [7:0] c);
    return c inside {8'h20, [8'h09:8'h0D]};
  endfunction

  function automatic morse_t morse_lookup(input logic [7:0] c);
    logic [7:0] u;
    morse_t     m;
    u = (c inside {["a":"z"]}) ? c - 8'd32 : c;
    case (u)
      "A": m = {1'b1, 3'd2, 6'b010000};
      "B": m = {1'b1, 3'd4, 6'b100000};
      "C": m = {1'b1, 3'd4, 6'b101000};
      "D": m = {1'b1, 3'd3, 6'b100000};
      "E": m = {1'b1, 3'd1, 6'b000000};
      "F": m = {1'b1, 3'd4, 6'b001000};
      "G": m = {1'b1, 3'd3, 6'b110000};
      "H": m = {1'b1, 3'd4, 6'b000000};
      "I": m = {1'b1, 3'd2, 6'b000000};
      "J": m = {1'b1, 3'd4, 6'b011100};
      "K": m = {1'b1, 3'd3, 6'b101000};
      "L": m = {1'b1, 3'd4, 6'b010000};
      "M": m = {1'b1, 3'd2, 6'b110000};
      "N": m = {1'b1, 3'd2, 6'b100000};
      "O": m = {1'b1, 3'd3, 6'b111000};
      "P": m = {1'b1, 3'd4, 6'b011000};
      "Q": m = {1'b1, 3'd4, 6'b110100};
      "R": m = {1'b1, 3'd3, 6'b010000};
      "S": m = {1'b1, 3'd3, 6'b000000};
      "T": m = {1'b1, 3'd1, 6'b100000};
      "U": m = {1'b1, 3'd3, 6'b001000};
      "V": m = {1'b1, 3'd4, 6'b000100};
      "W": m = {1'b1, 3'd3, 6'b011000};
      "X": m = {1'b1, 3'd4, 6'b100100};
      "Y": m = {1'b1, 3'd4, 6'b101100};
      "Z": m = {1'b1, 3'd4, 6'b110000};
      "0": m = {1'b1, 3'd5, 6'b111110};
      "1": m = {1'b1, 3'd5, 6'b011110};
      "2": m = {1'b1, 3'd5, 6'b001110};
      "3": m = {1'b1, 3'd5, 6'b000110};
      "4": m = {1'b1, 3'd5, 6'b000010};
      "5": m = {1'b1, 3'd5, 6'b000000};
      "6": m = {1'b1, 3'd5, 6'b100000};
      "7": m = {1'b1, 3'd5, 6'b110000};
      "8": m = {1'b1, 3'd5, 6'b111000};
      "9": m = {1'b1, 3'd5, 6'b111100};
      "/": m = {1'b1, 3'd5, 6'b100100};
      "?": m = {1'b1, 3'd6, 6'b001100};
      ".": m = {1'b1, 3'd6, 6'b010101};
      ",": m = {1'b1, 3'd6, 6'b110011};
      "-": m = {1'b1, 3'd6, 6'b100001};
      "+": m = {1'b1, 3'd5, 6'b010100};
      "=": m = {1'b1, 3'd5, 6'b100010};
      default: m = '0;
    endcase
    return m;
  endfunction

  function automatic logic [CODE_BITS-1:0] len_mask(input logic [2:0] len);
    return ~(6'h3F >> len);
  endfunction

  function automatic logic later_marks(input logic [CODE_BITS-1:0] p,
                                       input logic [CODE_BITS-1:0] m,
                                       input logic dot_nz,
                                       input logic dash_nz);
    return ((|(m & ~p)) & dot_nz) | ((|p) & dash_nz);
  endfunction

  function automatic ctrl_t ucode(input step_t s);
    ctrl_t w;
    case (s)
      ST_WAIT: w = '{take: 1'b1, emit: EMIT_NONE, cond: COND_DISPATCH, commit: 1'b0,
                     next_a: ST_WAIT, next_b: ST_WAIT};
      ST_GAP:  w = '{take: 1'b0, emit: EMIT_LEAD, cond: COND_EMIT, commit: 1'b0,
                     next_a: ST_MARK, next_b: ST_MARK};
      ST_MARK: w = '{take: 1'b0, emit: EMIT_KEY, cond: COND_MORE, commit: 1'b1,
                     next_a: ST_EGAP, next_b: ST_WAIT};
      ST_EGAP: w = '{take: 1'b0, emit: EMIT_EGAP, cond: COND_EMIT, commit: 1'b0,
                     next_a: ST_MARK, next_b: ST_MARK};
      ST_ERR:  w = '{take: 1'b0, emit: EMIT_ERR, cond: COND_EMIT, commit: 1'b0,
                     next_a: ST_WAIT, next_b: ST_WAIT};
      default: w = '{take: 1'b0, emit: EMIT_NONE, cond: COND_EMIT, commit: 1'b0,
                     next_a: ST_WAIT, next_b: ST_WAIT};
    endcase
    return w;
  endfunction

endpackage

/* rtl/core/mkeg_seq.sv */
// Microcode sequencer: step counter, control store and conditional jumps.
module mkeg_seq (
  input  logic              clk,
  input  logic              rst,
  input  mkeg_pkg::status_t stat,
  output mkeg_pkg::ctrl_t   ctrl
);
  import mkeg_pkg::*;

  step_t step;
  step_t step_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      step <= ST_WAIT;
    end else begin
      step <= step_next;
    end
  end

  always_comb begin
    step_next = step;
    case (ctrl.cond)
      COND_DISPATCH: begin
        if (stat.accept) begin
          if (stat.blank) begin
            step_next = ST_WAIT;
          end else if (stat.bad) begin
            step_next = ST_ERR;
          end else if (stat.prev) begin
            step_next = ST_GAP;
          end else begin
            step_next = ST_MARK;
          end
        end
      end
      COND_EMIT: begin
        if (stat.done) begin
          step_next = ctrl.next_a;
        end
      end
      COND_MORE: begin
        if (stat.done) begin
          step_next = stat.more ? ctrl.next_a : ctrl.next_b;
        end
      end
      default: step_next = ST_WAIT;
    endcase
  end

  always_comb begin
    ctrl = ucode(step);
  end

endmodule

/* rtl/core/morse_keying_event_generator_core.sv */
// Top level of the Morse keying event generator: datapath, registers and output stage.
//
// One message character enters per request on the input channel (symbol_char, new_message);
// the block answers with a run of keying events on the output channel, one event per
// transfer, with last_in_run set on the final event of the run. Whitespace gives no event,
// an unknown character gives a single event with bad_char set.
// Input is taken only while the sequencer waits at its dispatch step. A character is then
// accepted at the dispatch step and passes through one microcode step per possible event:
// an optional leading gap, then its marks separated by element gaps; an unknown character
// takes only the error step and whitespace none. The microcode sequencer issues one event
// step per cycle, and an event step waits while the output register is full and stalled;
// out_stall therefore holds back the whole sequencer but never loses or repeats an event.
// Configuration writes are accepted in every cycle and must be made while the block is
// idle. Reset restores the default timing registers, clears the time sum, position and
// gap state and empties the output register.
module morse_keying_event_generator_core (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [7:0]                          symbol_char,
  input  logic                                new_message,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [2:0]                          element_kind,
  output logic                                carrier_on,
  output logic                                tone_select,
  output logic [mkeg_pkg::TIME_BITS-1:0]      event_start,
  output logic [mkeg_pkg::LEN_BITS-1:0]       event_length,
  output logic [mkeg_pkg::POSITION_BITS-1:0]  char_position,
  output logic                                last_in_run,
  output logic                                bad_char,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [mkeg_pkg::CFG_IDX_BITS-1:0]   cfg_index,
  input  logic [mkeg_pkg::LEN_BITS-1:0]       cfg_data
);
  import mkeg_pkg::*;

  ctrl_t   ctrl;
  status_t stat;

  logic [1:0]          keying_mode;
  logic [LEN_BITS-1:0] dot_time;
  logic [LEN_BITS-1:0] dash_time;
  logic [LEN_BITS-1:0] element_gap_time;
  logic [LEN_BITS-1:0] letter_gap_time;
  logic [LEN_BITS-1:0] word_gap_time;

  logic [TIME_BITS-1:0]     elapsed_time;
  logic [TIME_BITS-1:0]     elapsed_time_next;
  logic [POSITION_BITS-1:0] position_counter;
  logic [POSITION_BITS-1:0] prev_char_position;
  logic [POSITION_BITS-1:0] cur_pos;
  logic                     have_prev_char;
  logic                     space_pending;
  logic [CODE_BITS-1:0]     pat;
  logic [CODE_BITS-1:0]     mask;

  morse_t                   lookup;
  logic                     accept;
  logic [POSITION_BITS-1:0] accept_pos;
  logic                     gap_carrier;
  logic [LEN_BITS-1:0]      dash_len;
  logic                     dot_nz;
  logic                     dash_nz;
  logic                     egap_nz;
  logic                     cur_dash;
  logic                     out_free;
  logic                     load_out;
  logic                     commit;
  logic [TIME_BITS:0]       time_sum;

  logic [2:0]               ev_kind;
  logic                     ev_carrier;
  logic                     ev_tone;
  logic [LEN_BITS-1:0]      ev_len;
  logic [POSITION_BITS-1:0] ev_pos;
  logic                     ev_later;
  logic                     ev_nz;

  mkeg_seq u_seq (
    .clk  (clk),
    .rst  (rst),
    .stat (stat),
    .ctrl (ctrl)
  );

  assign cfg_ready = 1'b1;
  assign in_stall  = ~ctrl.take;
  assign accept    = ctrl.take & in_valid;
  assign lookup    = morse_lookup(symbol_char);
  assign accept_pos = new_message ? '0 : position_counter;

  assign gap_carrier = (keying_mode == MODE_FSK);
  assign dash_len    = (keying_mode == MODE_DFCW) ? dot_time : dash_time;
  assign dot_nz      = |dot_time;
  assign dash_nz     = |dash_len;
  assign egap_nz     = |element_gap_time;
  assign cur_dash    = pat[CODE_BITS-1];
  assign out_free    = ~out_valid | ~out_stall;

  always_comb begin
    ev_kind    = KIND_DOT;
    ev_carrier = 1'b0;
    ev_tone    = 1'b0;
    ev_len     = '0;
    ev_pos     = cur_pos;
    ev_later   = 1'b0;
    case (ctrl.emit)
      EMIT_LEAD: begin
        ev_kind    = space_pending ? KIND_WGAP : KIND_LGAP;
        ev_carrier = gap_carrier;
        ev_tone    = gap_carrier;
        ev_len     = space_pending ? word_gap_time : letter_gap_time;
        ev_pos     = space_pending ? prev_char_position + 1'b1 : prev_char_position;
        ev_later   = later_marks(pat, mask, dot_nz, dash_nz) | (mask[CODE_BITS-2] & egap_nz);
      end
      EMIT_KEY: begin
        ev_kind    = cur_dash ? KIND_DASH : KIND_DOT;
        ev_carrier = 1'b1;
        ev_tone    = (keying_mode == MODE_DFCW) & cur_dash;
        ev_len     = cur_dash ? dash_len : dot_time;
        ev_later   = later_marks({pat[CODE_BITS-2:0], 1'b0}, {mask[CODE_BITS-2:0], 1'b0},
                                 dot_nz, dash_nz) | (mask[CODE_BITS-2] & egap_nz);
      end
      EMIT_EGAP: begin
        ev_kind    = KIND_EGAP;
        ev_carrier = gap_carrier;
        ev_tone    = gap_carrier;
        ev_len     = element_gap_time;
        ev_later   = later_marks(pat, mask, dot_nz, dash_nz) | (mask[CODE_BITS-2] & egap_nz);
      end
      default: begin
        ev_kind = KIND_DOT;
      end
    endcase
  end

  assign ev_nz = |ev_len;

  always_comb begin
    stat.accept = accept;
    stat.blank  = is_blank(symbol_char);
    stat.bad    = ~lookup.ok;
    stat.prev   = have_prev_char & ~new_message;
    stat.more   = mask[CODE_BITS-2];
    case (ctrl.emit)
      EMIT_NONE: stat.done = 1'b1;
      EMIT_ERR:  stat.done = out_free;
      default:   stat.done = out_free | ~ev_nz;
    endcase
  end

  assign load_out = out_free & ((ctrl.emit == EMIT_ERR) ||
                    (ev_nz && (ctrl.emit == EMIT_LEAD || ctrl.emit == EMIT_KEY ||
                               ctrl.emit == EMIT_EGAP)));
  assign commit   = ctrl.commit & stat.done & ~stat.more;

  assign time_sum = {1'b0, elapsed_time} + (TIME_BITS + 1)'(ev_len);
  assign elapsed_time_next = time_sum[TIME_BITS] ? '1 : time_sum[TIME_BITS-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      keying_mode      <= MODE_OOK;
      dot_time         <= RST_DOT;
      dash_time        <= RST_DASH;
      element_gap_time <= RST_ELEM_GAP;
      letter_gap_time  <= RST_LETTER_GAP;
      word_gap_time    <= RST_WORD_GAP;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_MODE:       keying_mode      <= cfg_data[1:0];
        CFG_DOT:        dot_time         <= cfg_data;
        CFG_DASH:       dash_time        <= cfg_data;
        CFG_ELEM_GAP:   element_gap_time <= cfg_data;
        CFG_LETTER_GAP: letter_gap_time  <= cfg_data;
        CFG_WORD_GAP:   word_gap_time    <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      elapsed_time       <= '0;
      position_counter   <= '0;
      prev_char_position <= '0;
      have_prev_char     <= 1'b0;
      space_pending      <= 1'b0;
    end else begin
      if (accept) begin
        position_counter <= accept_pos + 1'b1;
        if (new_message) begin
          elapsed_time   <= '0;
          have_prev_char <= 1'b0;
        end
        if (is_blank(symbol_char)) begin
          space_pending <= 1'b1;
        end else if (new_message) begin
          space_pending <= 1'b0;
        end
      end else if (load_out && ctrl.emit != EMIT_ERR) begin
        elapsed_time <= elapsed_time_next;
      end
      if (commit) begin
        have_prev_char     <= 1'b1;
        space_pending      <= 1'b0;
        prev_char_position <= cur_pos;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cur_pos <= accept_pos;
      pat     <= lookup.pat;
      mask    <= len_mask(lookup.len);
    end else if (ctrl.emit == EMIT_KEY && stat.done) begin
      pat  <= {pat[CODE_BITS-2:0], 1'b0};
      mask <= {mask[CODE_BITS-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      element_kind  <= ev_kind;
      carrier_on    <= ev_carrier;
      tone_select   <= ev_tone;
      event_start   <= elapsed_time;
      event_length  <= ev_len;
      char_position <= ev_pos;
      last_in_run   <= (ctrl.emit == EMIT_ERR) | ~ev_later;
      bad_char      <= (ctrl.emit == EMIT_ERR);
    end
  end

endmodule

/* sim/morse_keying_event_generator_core_tb.sv */
// Self-checking testbench for the Morse keying event generator core.
`timescale 1ns / 1ps

module morse_keying_event_generator_core_tb;
  import mkeg_pkg::*;

  localparam logic [1:0] MODE_UNDEF = 2'd3;
  localparam logic [TIME_BITS-1:0] TIME_MAX = {TIME_BITS{1'b1}};
  localparam logic [LEN_BITS-1:0] LEN_MAX = {LEN_BITS{1'b1}};
  localparam int DRAIN_CYCLES = 16;

  typedef struct packed {
    logic [2:0]               kind;
    logic                     carrier;
    logic                     tone;
    logic [TIME_BITS-1:0]     start;
    logic [LEN_BITS-1:0]      length;
    logic [POSITION_BITS-1:0] pos;
    logic                     last;
    logic                     bad;
  } key_event_t;

  typedef struct packed {
    logic [7:0] ch;
    logic       restart;
    logic       hand;
    key_event_t ev;
  } plan_row_t;

  localparam plan_row_t PLAN [25] = '{
    '{"E", 1'b0, 1'b1, '{KIND_DOT, 1'b1, 1'b0, 56'd0, RST_DOT, 16'd0, 1'b1, 1'b0}},
    '{"t", 1'b0, 1'b0, '0},
    '{8'h20, 1'b0, 1'b0, '0},
    '{"A", 1'b0, 1'b0, '0},
    '{8'h00, 1'b0, 1'b0, '0},
    '{8'hFF, 1'b1, 1'b1, '{KIND_DOT, 1'b0, 1'b0, 56'd0, 48'd0, 16'd0, 1'b1, 1'b1}},
    '{"T", 1'b1, 1'b1, '{KIND_DASH, 1'b1, 1'b0, 56'd0, RST_DASH, 16'd0, 1'b1, 1'b0}},
    '{"0", 1'b0, 1'b0, '0},
    '{8'h09, 1'b0, 1'b0, '0},
    '{"?", 1'b0, 1'b0, '0},
    '{".", 1'b0, 1'b0, '0},
    '{8'h0D, 1'b0, 1'b0, '0},
    '{",", 1'b0, 1'b0, '0},
    '{"-", 1'b0, 1'b0, '0},
    '{"+", 1'b0, 1'b0, '0},
    '{"=", 1'b0, 1'b0, '0},
    '{"/", 1'b0, 1'b0, '0},
    '{"z", 1'b0, 1'b0, '0},
    '{"9", 1'b0, 1'b0, '0},
    '{8'h7F, 1'b0, 1'b0, '0},
    '{"@", 1'b0, 1'b0, '0},
    '{8'h0E, 1'b0, 1'b0, '0},
    '{8'h08, 1'b0, 1'b0, '0},
    '{"Q", 1'b0, 1'b0, '0},
    '{"[", 1'b0, 1'b0, '0}
  };

  logic                     clk = 1'b0;
  logic                     rst = 1'b1;
  logic                     in_valid = 1'b0;
  logic                     in_stall;
  logic [7:0]               symbol_char = 8'd0;
  logic                     new_message = 1'b0;
  logic                     out_valid;
  logic                     out_stall = 1'b0;
  logic [2:0]               element_kind;
  logic                     carrier_on;
  logic                     tone_select;
  logic [TIME_BITS-1:0]     event_start;
  logic [LEN_BITS-1:0]      event_length;
  logic [POSITION_BITS-1:0] char_position;
  logic                     last_in_run;
  logic                     bad_char;
  logic                     cfg_valid = 1'b0;
  logic                     cfg_ready;
  logic [CFG_IDX_BITS-1:0]  cfg_index = '0;
  logic [LEN_BITS-1:0]      cfg_data = '0;

  logic [1:0]               mode_reg = MODE_OOK;
  logic [LEN_BITS-1:0]      dot_len = RST_DOT;
  logic [LEN_BITS-1:0]      dash_len = RST_DASH;
  logic [LEN_BITS-1:0]      egap_len = RST_ELEM_GAP;
  logic [LEN_BITS-1:0]      lgap_len = RST_LETTER_GAP;
  logic [LEN_BITS-1:0]      wgap_len = RST_WORD_GAP;
  logic [TIME_BITS-1:0]     run_time = '0;
  logic [POSITION_BITS-1:0] next_pos = '0;
  logic [POSITION_BITS-1:0] prev_pos = '0;
  logic                     have_prev = 1'b0;
  logic                     gap_pending = 1'b0;

  key_event_t char_events[$];
  key_event_t events_due[$];
  string      morse_chars =
    "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789/?.,-+=";
  int         in_idle_pct = 30;
  int         out_stall_pct = 30;
  int         errors = 0;
  int         chars_sent = 0;
  int         events_seen = 0;

  morse_keying_event_generator_core dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .symbol_char(symbol_char),
    .new_message(new_message),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .element_kind(element_kind),
    .carrier_on(carrier_on),
    .tone_select(tone_select),
    .event_start(event_start),
    .event_length(event_length),
    .char_position(char_position),
    .last_in_run(last_in_run),
    .bad_char(bad_char),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic logic is_space(input logic [7:0] c);
    return (c == 8'h20) || (c >= 8'h09 && c <= 8'h0D);
  endfunction

  function automatic string code_for(input logic [7:0] c);
    logic [7:0] u;
    u = (c >= "a" && c <= "z") ? c - 8'd32 : c;
    case (u)
      "A": return ".-";    "B": return "-...";  "C": return "-.-.";  "D": return "-..";
      "E": return ".";     "F": return "..-.";  "G": return "--.";   "H": return "....";
      "I": return "..";    "J": return ".---";  "K": return "-.-";   "L": return ".-..";
      "M": return "--";    "N": return "-.";    "O": return "---";   "P": return ".--.";
      "Q": return "--.-";  "R": return ".-.";   "S": return "...";   "T": return "-";
      "U": return "..-";   "V": return "...-";  "W": return ".--";   "X": return "-..-";
      "Y": return "-.--";  "Z": return "--..";
      "0": return "-----"; "1": return ".----"; "2": return "..---"; "3": return "...--";
      "4": return "....-"; "5": return "....."; "6": return "-...."; "7": return "--...";
      "8": return "---.."; "9": return "----.";
      "/": return "-..-.";  "?": return "..--.."; ".": return ".-.-.-"; ",": return "--..--";
      "-": return "-....-"; "+": return ".-.-.";  "=": return "-...-";
      default: return "";
    endcase
  endfunction

  task automatic add_event(input logic [2:0] kind, input logic carrier, input logic tone,
                           input logic [LEN_BITS-1:0] len, input logic [POSITION_BITS-1:0] pos);
    key_event_t ev;
    if (len == '0) return;
    ev = '{kind, carrier, tone, run_time, len, pos, 1'b0, 1'b0};
    char_events.insert(char_events.size(), ev);
    if ({{(TIME_BITS-LEN_BITS){1'b0}}, len} > TIME_MAX - run_time) run_time = TIME_MAX;
    else run_time = run_time + len;
  endtask

  task automatic expand_char(input logic [7:0] ch, input logic restart);
    string                    code;
    logic [POSITION_BITS-1:0] pos;
    logic                     gap_on;
    logic                     is_dash;
    key_event_t               bad_ev;
    int                       j;
    char_events.delete();
    gap_on = (mode_reg == MODE_FSK);
    if (restart) begin
      run_time = '0;
      next_pos = '0;
      have_prev = 1'b0;
      gap_pending = 1'b0;
    end
    pos = next_pos;
    next_pos = next_pos + 1'b1;
    if (is_space(ch)) begin
      gap_pending = 1'b1;
      return;
    end
    code = code_for(ch);
    if (code.len() == 0) begin
      bad_ev = '{KIND_DOT, 1'b0, 1'b0, run_time, '0, pos, 1'b1, 1'b1};
      char_events.insert(char_events.size(), bad_ev);
      return;
    end
    if (have_prev) begin
      if (gap_pending) add_event(KIND_WGAP, gap_on, gap_on, wgap_len, prev_pos + 1'b1);
      else add_event(KIND_LGAP, gap_on, gap_on, lgap_len, prev_pos);
    end
    for (j = 0; j < code.len(); j++) begin
      is_dash = (code[j] == "-");
      if (mode_reg == MODE_DFCW)
        add_event(is_dash ? KIND_DASH : KIND_DOT, 1'b1, is_dash, dot_len, pos);
      else
        add_event(is_dash ? KIND_DASH : KIND_DOT, 1'b1, 1'b0, is_dash ? dash_len : dot_len, pos);
      if (j < code.len() - 1) add_event(KIND_EGAP, gap_on, gap_on, egap_len, pos);
    end
    have_prev = 1'b1;
    gap_pending = 1'b0;
    prev_pos = pos;
    if (char_events.size() > 0) char_events[char_events.size()-1].last = 1'b1;
  endtask

  task automatic push_request(input logic [7:0] ch, input logic restart, input logic hand,
                              input key_event_t hand_ev);
    while ($urandom_range(99) < in_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    symbol_char <= ch;
    new_message <= restart;
    do @(posedge clk); while (in_stall);
    chars_sent++;
    expand_char(ch, restart);
    if (hand) events_due.insert(events_due.size(), hand_ev);
    else foreach (char_events[i]) events_due.insert(events_due.size(), char_events[i]);
  endtask

  task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx, input logic [LEN_BITS-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_MODE:       mode_reg = val[1:0];
      CFG_DOT:        dot_len = val;
      CFG_DASH:       dash_len = val;
      CFG_ELEM_GAP:   egap_len = val;
      CFG_LETTER_GAP: lgap_len = val;
      CFG_WORD_GAP:   wgap_len = val;
      default: ;
    endcase
  endtask

  task automatic program_timing(input logic [1:0] mode, input logic [LEN_BITS-1:0] dot,
                                input logic [LEN_BITS-1:0] dash, input logic [LEN_BITS-1:0] egap,
                                input logic [LEN_BITS-1:0] lgap, input logic [LEN_BITS-1:0] wgap);
    logic [LEN_BITS-1:0] mode_word;
    mode_word = LEN_BITS'({$urandom, $urandom});
    mode_word[1:0] = mode;
    write_reg(CFG_MODE, mode_word);
    write_reg(CFG_DOT, dot);
    write_reg(CFG_DASH, dash);
    write_reg(CFG_ELEM_GAP, egap);
    write_reg(CFG_LETTER_GAP, lgap);
    write_reg(CFG_WORD_GAP, wgap);
    cfg_valid <= 1'b0;
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (events_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic logic [7:0] pick_char();
    int roll;
    int blank_sel;
    roll = $urandom_range(99);
    if (roll < 70) return morse_chars[$urandom_range(morse_chars.len() - 1)];
    if (roll < 85) begin
      blank_sel = $urandom_range(5);
      return (blank_sel == 5) ? 8'h20 : 8'h09 + 8'(blank_sel);
    end
    return 8'($urandom_range(255));
  endfunction

  function automatic logic [LEN_BITS-1:0] pick_len(input int zero_pct);
    logic [LEN_BITS-1:0] v;
    if ($urandom_range(99) < zero_pct) return '0;
    case ($urandom_range(2))
      0: v = LEN_BITS'($urandom_range(64, 1));
      1: v = LEN_BITS'($urandom_range(1000000, 1));
      default: v = LEN_BITS'({$urandom, $urandom});
    endcase
    return (v == '0) ? LEN_BITS'(1) : v;
  endfunction

  task automatic run_messages(input int count, input int restart_pct);
    repeat (count) push_request(pick_char(), $urandom_range(99) < restart_pct, 1'b0, '0);
    settle();
  endtask

  task automatic check_field(input string name, input logic [63:0] want, input logic [63:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      errors++;
    end
  endtask

  task automatic check_event();
    key_event_t want;
    events_seen++;
    if (events_due.size() == 0) begin
      $error("Event with no request outstanding: kind %0d, position %0d",
             element_kind, char_position);
      errors++;
      return;
    end
    want = events_due.pop_front();
    check_field("element_kind", want.kind, element_kind);
    check_field("carrier_on", want.carrier, carrier_on);
    check_field("tone_select", want.tone, tone_select);
    check_field("event_start", want.start, event_start);
    check_field("event_length", want.length, event_length);
    check_field("char_position", want.pos, char_position);
    check_field("last_in_run", want.last, last_in_run);
    check_field("bad_char", want.bad, bad_char);
  endtask

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) check_event();
    out_stall <= ($urandom_range(99) < out_stall_pct);
  end

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    foreach (PLAN[i]) push_request(PLAN[i].ch, PLAN[i].restart, PLAN[i].hand, PLAN[i].ev);
    settle();

    in_idle_pct = 0;
    out_stall_pct = 0;
    program_timing(MODE_FSK, pick_len(0), pick_len(0), pick_len(0), pick_len(0), pick_len(0));
    run_messages(60, 3);
    in_idle_pct = 30;
    out_stall_pct = 30;

    program_timing(MODE_DFCW, pick_len(0), pick_len(0), pick_len(0), pick_len(0), pick_len(0));
    run_messages(60, 3);

    program_timing(MODE_UNDEF, pick_len(0), pick_len(0), pick_len(0), pick_len(0), pick_len(0));
    run_messages(40, 3);

    program_timing(MODE_OOK, LEN_MAX, LEN_MAX, LEN_MAX, LEN_MAX, LEN_MAX);
    run_messages(60, 0);

    program_timing(MODE_FSK, 48'd1, 48'd1, 48'd1, 48'd1, 48'd1);
    run_messages(40, 3);

    repeat (2) begin
      program_timing(2'($urandom_range(3)), pick_len(50), pick_len(50), pick_len(50),
                     pick_len(50), pick_len(50));
      run_messages(50, 3);
    end

    program_timing(2'($urandom_range(3)), pick_len(0), pick_len(0), pick_len(0),
                   pick_len(0), pick_len(0));
    run_messages(50, 3);

    $display("Sent %0d characters in all four keying modes and checked %0d events.",
             chars_sent, events_seen);
    $display("Included minimum, maximum and zero timings and time saturation.");
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin
    #8000000;
    $display("TB_ERROR");
    $finish;
  end

endmodule
